// ----- src/q2a_pkg.sv -----
// Shared types, constants and CORDIC angle table for the quaternion to attitude block.
`timescale 1ns / 1ps
`default_nettype none
package q2a_pkg;

	localparam int QW = 16;
	localparam int OW = 16;
	localparam int PW = 15;
	// CORDIC operand width: magnitudes up to about 2^34 grow by 1.65
	localparam int CW = 38;
	// angle accumulator, degrees * 65536
	localparam int AW = 26;
	localparam int TAB_N = 24;

	localparam logic signed [15:0] MAT_LIM = 16'sd16384;
	localparam logic signed [15:0] ANG_LIM = 16'sd23040;
	localparam logic signed [15:0] PIT_LIM = 16'sd11520;
	localparam logic signed [AW-1:0] DEG180 = AW'(180 * 65536);
	localparam logic signed [63:0] ONE_Q30 = 64'sd1 << 30;

	typedef logic signed [CW-1:0] cw_t;
	typedef logic signed [AW-1:0] ang_t;

	// atan(2^-i) in degrees * 65536
	function automatic ang_t atan_tab(input logic [4:0] i);
		ang_t r;
		unique case (i)
			5'd0: r = AW'(2949120);
			5'd1: r = AW'(1740967);
			5'd2: r = AW'(919879);
			5'd3: r = AW'(466945);
			5'd4: r = AW'(234379);
			5'd5: r = AW'(117304);
			5'd6: r = AW'(58666);
			5'd7: r = AW'(29335);
			5'd8: r = AW'(14668);
			5'd9: r = AW'(7334);
			5'd10: r = AW'(3667);
			5'd11: r = AW'(1833);
			5'd12: r = AW'(917);
			5'd13: r = AW'(458);
			5'd14: r = AW'(229);
			5'd15: r = AW'(115);
			5'd16: r = AW'(57);
			5'd17: r = AW'(29);
			5'd18: r = AW'(14);
			5'd19: r = AW'(7);
			5'd20: r = AW'(4);
			5'd21: r = AW'(2);
			5'd22: r = AW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

	// vector state of one CORDIC lane
	typedef struct packed {
		cw_t x;
		cw_t y;
		ang_t z;
	} vec_t;

	// three lanes: roll, pitch, yaw
	typedef struct packed {
		vec_t roll;
		vec_t pitch;
		vec_t yaw;
	} lanes_t;

	typedef logic signed [15:0] mat_t [9];

endpackage
`default_nettype wire

// ----- src/q2a_sqrt_stage.sv -----
// One stage of the pipelined bit-pair square root, two result bits a stage.
`timescale 1ns / 1ps
`default_nettype none
module q2a_sqrt_stage #(
	parameter int STEP = 0,
	parameter int PAYW = 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            vin,
	input  wire logic [61:0]     n_in,
	input  wire logic [61:0]     r_in,
	input  wire logic [PAYW-1:0] pay_in,
	output logic                 vout,
	output logic [61:0]          n_out,
	output logic [61:0]          r_out,
	output logic [PAYW-1:0]      pay_out
);
	// two restoring steps, bit positions 60-4*STEP and 58-4*STEP
	localparam int B0 = 60 - 4 * STEP;
	localparam int B1 = 58 - 4 * STEP;
	// the last stage of a 31-bit root has only the first step
	localparam bit HAS1 = (B1 >= 0);
	localparam int S1 = HAS1 ? B1 : 0;

	logic [63:0] n0, r0, n1, r1, n2, r2, t;

	always_comb begin
		n0 = {2'b00, n_in};
		r0 = {2'b00, r_in};
		t = r0 + (64'd1 << B0);
		if (n0 >= t) begin
			n1 = n0 - t;
			r1 = (r0 >> 1) + (64'd1 << B0);
		end else begin
			n1 = n0;
			r1 = r0 >> 1;
		end
		t = r1 + (64'd1 << S1);
		if (!HAS1) begin
			n2 = n1;
			r2 = r1;
		end else if (n1 >= t) begin
			n2 = n1 - t;
			r2 = (r1 >> 1) + (64'd1 << S1);
		end else begin
			n2 = n1;
			r2 = r1 >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_out <= n2[61:0];
			r_out <= r2[61:0];
			pay_out <= pay_in;
		end
	end
endmodule
`default_nettype wire

// ----- src/q2a_cordic_stage.sv -----
// One vectoring micro-rotation for the three angle lanes.
`timescale 1ns / 1ps
`default_nettype none
module q2a_cordic_stage #(
	parameter int IDX = 0,
	parameter int PAYW = 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            vin,
	input  wire q2a_pkg::lanes_t lin,
	input  wire logic [PAYW-1:0] pay_in,
	output logic                 vout,
	output q2a_pkg::lanes_t      lout,
	output logic [PAYW-1:0]      pay_out
);
	import q2a_pkg::*;

	localparam ang_t ATAB = atan_tab(5'(IDX));

	function automatic vec_t rot(input vec_t v);
		vec_t o;
		cw_t xs, ys;
		xs = v.x >>> IDX;
		ys = v.y >>> IDX;
		if (!v.y[CW-1]) begin
			o.x = v.x + ys;
			o.y = v.y - xs;
			o.z = v.z + ATAB;
		end else begin
			o.x = v.x - ys;
			o.y = v.y + xs;
			o.z = v.z - ATAB;
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lout.roll <= rot(lin.roll);
			lout.pitch <= rot(lin.pitch);
			lout.yaw <= rot(lin.yaw);
			pay_out <= pay_in;
		end
	end
endmodule
`default_nettype wire

// ----- src/quaternion_to_attitude.sv -----
// Top level: quaternion products, rotation matrix, square root and CORDIC pipeline.
// Throughput: one quaternion per cycle while the output is not stalled; products, 16
// square-root stages and one CORDIC stage per micro-rotation each form a register stage.
// A stalled output freezes the whole pipeline; input ready follows output space.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_attitude #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
	input  wire logic [63:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// rot_00..rot_22 [143:0], roll_angle[159:144], pitch_angle[174:160],
	// yaw_angle[190:175], zero fill [191]
	output logic [191:0]      m_tdata
);
	import q2a_pkg::*;

	localparam int NS = (CORDIC_STAGES > TAB_N) ? TAB_N : CORDIC_STAGES;
	localparam int SQ = 16;
	localparam int MATW = 144;

	// whole pipeline advances when the output register can take data
	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: products
	logic v_s1;
	logic signed [31:0] ww_s1, wx_s1, wy_s1, wz_s1, xx_s1, xy_s1, xz_s1, yy_s1, yz_s1, zz_s1;
	logic signed [15:0] qw, qx, qy, qz;
	assign qw = s_tdata[15:0];
	assign qx = s_tdata[31:16];
	assign qy = s_tdata[47:32];
	assign qz = s_tdata[63:48];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= qw * qw; wx_s1 <= qw * qx; wy_s1 <= qw * qy; wz_s1 <= qw * qz;
			xx_s1 <= qx * qx; xy_s1 <= qx * qy; xz_s1 <= qx * qz;
			yy_s1 <= qy * qy; yz_s1 <= qy * qz; zz_s1 <= qz * qz;
		end
	end

	// stage 2: matrix entries and CORDIC operands
	function automatic logic signed [15:0] ment(input logic signed [33:0] s,
		input logic signed [15:0] bias);
		logic signed [33:0] r;
		r = ((s + 34'sd16384) >>> 15) + 34'(bias);
		if (r > 34'sd16384) r = 34'sd16384;
		else if (r < -34'sd16384) r = -34'sd16384;
		return r[15:0];
	endfunction

	logic v_s2;
	logic [MATW-1:0] mat_s2;
	logic signed [CW-1:0] ry_s2, rx_s2, yy2_s2, yx_s2;
	logic signed [31:0] pv_s2;
	logic signed [33:0] e0, e1, e2, e3, e4, e5, e6, e7, e8;
	logic signed [35:0] pvw;
	logic signed [31:0] pvc;

	always_comb begin
		e0 = 34'(ww_s1) + 34'(xx_s1);
		e1 = 34'(xy_s1) - 34'(wz_s1);
		e2 = 34'(xz_s1) + 34'(wy_s1);
		e3 = 34'(xy_s1) + 34'(wz_s1);
		e4 = 34'(ww_s1) + 34'(yy_s1);
		e5 = 34'(yz_s1) - 34'(wx_s1);
		e6 = 34'(xz_s1) - 34'(wy_s1);
		e7 = 34'(yz_s1) + 34'(wx_s1);
		e8 = 34'(ww_s1) + 34'(zz_s1);
		pvw = (36'(wy_s1) - 36'(xz_s1)) <<< 1;
		if (pvw > 36'sd1073741824) pvc = 32'sd1073741824;
		else if (pvw < -36'sd1073741824) pvc = -32'sd1073741824;
		else pvc = pvw[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mat_s2 <= {ment(e8, -MAT_LIM), ment(e7, '0), ment(e6, '0),
				ment(e5, '0), ment(e4, -MAT_LIM), ment(e3, '0),
				ment(e2, '0), ment(e1, '0), ment(e0, -MAT_LIM)};
			ry_s2 <= (CW'(wx_s1) + CW'(yz_s1)) <<< 1;
			rx_s2 <= CW'(ONE_Q30) - ((CW'(xx_s1) + CW'(yy_s1)) <<< 1);
			yy2_s2 <= (CW'(xy_s1) + CW'(wz_s1)) <<< 1;
			yx_s2 <= CW'(ONE_Q30) - ((CW'(yy_s1) + CW'(zz_s1)) <<< 1);
			pv_s2 <= pvc;
		end
	end

	// stage 3: radicand 2^60 - v^2
	localparam int PAY0 = MATW + 4 * CW + 32;
	logic v_s3;
	logic [61:0] rad_s3;
	logic [PAY0-1:0] pay_s3;
	logic [30:0] pva;
	assign pva = pv_s2[31] ? 31'(-pv_s2) : pv_s2[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= 62'((64'd1 << 60) - 64'(pva) * 64'(pva));
			pay_s3 <= {mat_s2, ry_s2, rx_s2, yy2_s2, yx_s2, pv_s2};
		end
	end

	// square-root pipeline
	logic [SQ:0] sv;
	logic [61:0] sn [SQ+1];
	logic [61:0] sr [SQ+1];
	logic [PAY0-1:0] sp [SQ+1];
	assign sv[0] = v_s3;
	assign sn[0] = rad_s3;
	assign sr[0] = '0;
	assign sp[0] = pay_s3;

	for (genvar g = 0; g < SQ; g++) begin : g_sq
		q2a_sqrt_stage #(.STEP(g), .PAYW(PAY0)) u_sq (
			.clk(clk), .arst_n(arst_n), .en(en), .vin(sv[g]),
			.n_in(sn[g]), .r_in(sr[g]), .pay_in(sp[g]),
			.vout(sv[g+1]), .n_out(sn[g+1]), .r_out(sr[g+1]), .pay_out(sp[g+1]));
	end

	// CORDIC pre-rotation
	function automatic vec_t prerot(input cw_t y, input cw_t x);
		vec_t o;
		o.x = x;
		o.y = y;
		o.z = '0;
		if (x[CW-1]) begin
			o.x = -x;
			o.y = -y;
			o.z = y[CW-1] ? -DEG180 : DEG180;
		end
		return o;
	endfunction

	logic [MATW-1:0] mat_q;
	cw_t ry_c, rx_c, yy_c, yx_c, pv_c;
	logic [31:0] pv_raw;
	assign {mat_q, ry_c, rx_c, yy_c, yx_c, pv_raw} = sp[SQ];
	assign pv_c = CW'($signed(pv_raw));

	logic v_s4;
	lanes_t l_s4;
	logic [MATW+3-1:0] p_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= sv[SQ];
	end
	// zero flags: both operands zero gives angle 0
	always_ff @(posedge clk) begin
		if (en) begin
			l_s4.roll <= prerot(ry_c, rx_c);
			l_s4.pitch <= prerot(pv_c, CW'(sr[SQ]));
			l_s4.yaw <= prerot(yy_c, yx_c);
			p_s4 <= {mat_q, (ry_c == '0 && rx_c == '0), (pv_c == '0 && sr[SQ] == '0),
				(yy_c == '0 && yx_c == '0)};
		end
	end

	logic [NS:0] cv;
	lanes_t cl [NS+1];
	logic [MATW+3-1:0] cp [NS+1];
	assign cv[0] = v_s4;
	assign cl[0] = l_s4;
	assign cp[0] = p_s4;
	for (genvar g = 0; g < NS; g++) begin : g_cd
		q2a_cordic_stage #(.IDX(g), .PAYW(MATW + 3)) u_cd (
			.clk(clk), .arst_n(arst_n), .en(en), .vin(cv[g]), .lin(cl[g]),
			.pay_in(cp[g]), .vout(cv[g+1]), .lout(cl[g+1]), .pay_out(cp[g+1]));
	end

	// final rounding, negation, saturation
	function automatic logic signed [15:0] fin(input ang_t z, input logic zf,
		input logic neg, input logic signed [15:0] lim);
		logic signed [AW:0] r;
		r = (AW+1)'((z + AW'(256)) >>> 9);
		if (zf) r = '0;
		if (neg) r = -r;
		if (r > (AW+1)'(lim)) r = (AW+1)'(lim);
		else if (r < -(AW+1)'(lim)) r = -(AW+1)'(lim);
		return r[15:0];
	endfunction

	logic signed [15:0] roll_o, pit_o, yaw_o;
	logic [MATW+3-1:0] pf;
	assign pf = cp[NS];
	assign roll_o = fin(cl[NS].roll.z, pf[2], 1'b0, ANG_LIM);
	assign pit_o = fin(cl[NS].pitch.z, pf[1], 1'b1, PIT_LIM);
	assign yaw_o = fin(cl[NS].yaw.z, pf[0], 1'b1, ANG_LIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= cv[NS];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {1'b0, yaw_o, pit_o[14:0], roll_o, pf[MATW+2:3]};
		end
	end
endmodule
`default_nettype wire

// ----- src/q2a_checker.sv -----
// Port-level checker for the quaternion to attitude block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module q2a_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [191:0] m_tdata
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");
	// input side stalls exactly when output is stalled
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready not tied to output space");
	// pad bit stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[191])
		else $error("pad bit set");
	// pitch within +-90 degrees
	a_pit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[174:160]) <= 15'sd11520 &&
			$signed(m_tdata[174:160]) >= -15'sd11520))
		else $error("pitch out of range");
endmodule

bind quaternion_to_attitude q2a_checker u_q2a_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));
`default_nettype wire

// ----- dv/quaternion_to_attitude_tb.sv -----
// Self-checking testbench for the quaternion to attitude converter.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_attitude_tb;
	import q2a_pkg::*;

	localparam int STAGES = 16;
	localparam int LATENCY = 21 + STAGES;

	typedef struct packed {
		logic signed [15:0] yaw;
		logic signed [14:0] pitch;
		logic signed [15:0] roll;
		logic signed [15:0] m22, m21, m20, m12, m11, m10, m02, m01, m00;
	} attitude_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;

	attitude_t expected_q[$];
	int        errors;
	int        rx_count;
	bit        rx_pause;

	quaternion_to_attitude #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#20ms;
		$display("[quaternion_to_attitude] ERROR");
		$finish;
	end

	// atan(2^-i), degrees * 65536
	function automatic longint atan_step(int i);
		longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
			4, 2, 1, 0};
		return t[i];
	endfunction

	function automatic longint floor_shift(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint round_shift(longint v, int k);
		return (v + (64'sd1 <<< (k - 1))) >>> k;
	endfunction

	function automatic longint clip(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	// vectoring-mode CORDIC, result in degrees * 65536
	function automatic longint vector_angle(longint y, longint x);
		longint ang, xs, ys;
		ang = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			ang = (y >= 0) ? 180 * 65536 : -180 * 65536;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STAGES; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; ang += atan_step(i);
			end else begin
				x -= ys; y += xs; ang -= atan_step(i);
			end
		end
		return ang;
	endfunction

	function automatic logic signed [15:0] mat_term(longint a, longint b, longint bias);
		return 16'(clip(round_shift(a + b, 15) + bias, 16384));
	endfunction

	function automatic attitude_t attitude_of(logic [63:0] q);
		longint w, x, y, z, ww, wx, wy, wz, xx, xy, xz, yy, yz, zz, v, c;
		longint unsigned vv;
		attitude_t r;
		w = longint'($signed(q[15:0]));
		x = longint'($signed(q[31:16]));
		y = longint'($signed(q[47:32]));
		z = longint'($signed(q[63:48]));
		ww = w * w; wx = w * x; wy = w * y; wz = w * z;
		xx = x * x; xy = x * y; xz = x * z;
		yy = y * y; yz = y * z; zz = z * z;
		r.m00 = mat_term(ww, xx, -16384);
		r.m01 = mat_term(xy, -wz, 0);
		r.m02 = mat_term(xz, wy, 0);
		r.m10 = mat_term(xy, wz, 0);
		r.m11 = mat_term(ww, yy, -16384);
		r.m12 = mat_term(yz, -wx, 0);
		r.m20 = mat_term(xz, -wy, 0);
		r.m21 = mat_term(yz, wx, 0);
		r.m22 = mat_term(ww, zz, -16384);
		r.roll = 16'(clip(round_shift(vector_angle(2 * (wx + yz),
			(64'sd1 <<< 30) - 2 * (xx + yy)), 9), 23040));
		v = clip(2 * (wy - xz), 64'sd1 <<< 30);
		vv = longint'(v < 0 ? -v : v);
		c = int_sqrt((64'd1 << 60) - vv * vv);
		r.pitch = 15'(clip(-round_shift(vector_angle(v, c), 9), 11520));
		r.yaw = 16'(clip(-round_shift(vector_angle(2 * (xy + wz),
			(64'sd1 <<< 30) - 2 * (yy + zz)), 9), 23040));
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch result %0d %s: got %0d want %0d", rx_count, field, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		attitude_t got, want;
		if (m_tvalid && m_tready) begin
			got = attitude_t'(m_tdata[190:0]);
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected", 1, 0);
			end else begin
				want = expected_q.pop_front();
				if (m_tdata[191] !== 1'b0) report_mismatch("fill", m_tdata[191], 0);
				if (got.m00 !== want.m00) report_mismatch("rot_00", got.m00, want.m00);
				if (got.m01 !== want.m01) report_mismatch("rot_01", got.m01, want.m01);
				if (got.m02 !== want.m02) report_mismatch("rot_02", got.m02, want.m02);
				if (got.m10 !== want.m10) report_mismatch("rot_10", got.m10, want.m10);
				if (got.m11 !== want.m11) report_mismatch("rot_11", got.m11, want.m11);
				if (got.m12 !== want.m12) report_mismatch("rot_12", got.m12, want.m12);
				if (got.m20 !== want.m20) report_mismatch("rot_20", got.m20, want.m20);
				if (got.m21 !== want.m21) report_mismatch("rot_21", got.m21, want.m21);
				if (got.m22 !== want.m22) report_mismatch("rot_22", got.m22, want.m22);
				if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
				if (got.pitch !== want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
				if (got.yaw !== want.yaw) report_mismatch("yaw", got.yaw, want.yaw);
			end
			rx_count++;
		end
	end

	// receiver stalls: random-length ready and stall windows; no stalls under rx_pause
	initial begin
		int run;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(1, 30);
			repeat (run) begin
				@(posedge clk);
				m_tready <= 1'b1;
			end
			if (!rx_pause && $urandom_range(0, 2) != 0) begin
				run = $urandom_range(1, 12);
				repeat (run) begin
					@(posedge clk);
					m_tready <= 1'b0;
				end
			end
		end
	end

	// send one request and record its expected result
	task automatic send_quat(logic [63:0] q);
		s_tvalid <= 1'b1;
		s_tdata  <= q;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_q.push_back(attitude_of(q));
	endtask

	task automatic idle_gap(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [63:0] pack_quat(int w, int x, int y, int z);
		return {16'(z), 16'(y), 16'(x), 16'(w)};
	endfunction

	// extremes, identity, axis rotations, clamp and zero-vector cases, then random mixes of those values
	task automatic test_directed();
		int vals[6] = '{0, 32767, -32768, 23170, -23170, 1};
		send_quat(pack_quat(0, 0, 0, 0));
		send_quat(pack_quat(32767, 0, 0, 0));
		send_quat(pack_quat(-32768, 0, 0, 0));
		send_quat(pack_quat(0, 32767, 0, 0));
		send_quat(pack_quat(0, 0, 32767, 0));
		send_quat(pack_quat(0, 0, 0, 32767));
		send_quat(pack_quat(0, -32768, 0, 0));
		send_quat(pack_quat(23170, 23170, 0, 0));
		send_quat(pack_quat(23170, 0, 23170, 0));
		send_quat(pack_quat(23170, 0, -23170, 0));
		send_quat(pack_quat(23170, 0, 0, 23170));
		send_quat(pack_quat(32767, 0, 32767, 0));
		send_quat(pack_quat(-32768, 0, 32767, 32767));
		send_quat(pack_quat(32767, 32767, 32767, 32767));
		send_quat(pack_quat(-32768, -32768, -32768, -32768));
		send_quat(pack_quat(0, 0, 0, 1));
		for (int i = 0; i < 8; i++)
			send_quat(pack_quat(vals[$urandom_range(0, 5)], vals[$urandom_range(0, 5)],
				vals[$urandom_range(0, 5)], vals[$urandom_range(0, 5)]));
		idle_gap(1);
	endtask

	// hold the sender until the pipeline has drained
	task automatic wait_drained();
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// near-unit quaternions with random content, plus raw noise
	task automatic test_random(int count);
		int burst;
		real a, b, c, d, n;
		logic [63:0] q;
		while (count > 0) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && count > 0; i++, count--) begin
				if ($urandom_range(0, 3) == 0) begin
					q = {$urandom, $urandom};
				end else begin
					a = real'($urandom_range(0, 65534)) - 32767.0;
					b = real'($urandom_range(0, 65534)) - 32767.0;
					c = real'($urandom_range(0, 65534)) - 32767.0;
					d = real'($urandom_range(0, 65534)) - 32767.0;
					n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
					q = pack_quat(int'(a * 32767.0 / n), int'(b * 32767.0 / n),
						int'(c * 32767.0 / n), int'(d * 32767.0 / n));
				end
				send_quat(q);
			end
			if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 15));
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		int waited;
		errors = 0;
		rx_count = 0;
		rx_pause = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_drained();
		rx_pause = 1'b1;
		test_random(200);
		rx_pause = 1'b0;
		wait_drained();
		test_random(1550);

		waited = 0;
		while (expected_q.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("[quaternion_to_attitude] OK");
		end else begin
			$display("[quaternion_to_attitude] ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
